FILE: hw/rtl/rts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rts_pkg;

    // Status codes returned with every result beat
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NEGATIVE = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam int ALU_BITS   = 64;
    localparam int STEP_BITS  = 6;
    localparam logic [STEP_BITS-1:0] LAST_WIDE_STEP = 6'd63;
    localparam logic [STEP_BITS-1:0] LAST_ROOT_STEP = 6'd31;
    localparam logic [30:0] JITTER_MAX = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_PREP,
        ST_MEAN_DIV,
        ST_MEAN_UPD,
        ST_DEV_PREP,
        ST_DEV_MUL,
        ST_DEV_UPD,
        ST_JIT_CHECK,
        ST_JIT_DIV,
        ST_SQRT_PREP,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        ALU_HOLD,
        ALU_DIV_LOAD,
        ALU_DIV_STEP,
        ALU_MUL_LOAD,
        ALU_MUL_STEP,
        ALU_SQRT_LOAD,
        ALU_SQRT_STEP
    } alu_op_t;

    typedef struct packed {
        logic fire;
        logic add_item;
        logic jit_needed;
        logic out_free;
    } ctrl_in_t;

    typedef struct packed {
        state_t  state;
        alu_op_t op;
    } ctrl_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rts_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rts_in_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output command, output sample, input ready);
    modport sink (input valid, input command, input sample, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rts_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rts_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] count;
    logic [30:0] average;
    logic [30:0] smallest;
    logic [30:0] largest;
    logic [30:0] jitter;

    modport source (output valid, output status, output count, output average,
                    output smallest, output largest, output jitter, input ready);
    modport sink (input valid, input status, input count, input average,
                  input smallest, input largest, input jitter, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rts_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared iterative unit: restoring divide, shift-add multiply, digit-by-digit
// square root, one bit (or one root digit) per cycle while a step op is applied.
module rts_alu (
    input  wire logic              clk,
    input  wire rts_pkg::alu_op_t  op,
    input  wire logic [63:0]       opa,
    input  wire logic [63:0]       opb,
    output logic [63:0]            quotient,
    output logic [63:0]            product_term,
    output logic [31:0]            root
);
    logic [63:0]  acc_reg, acc_next;
    logic [63:0]  aux_reg, aux_next;
    logic [63:0]  rem_reg, rem_next;
    logic [127:0] prod_reg, prod_next;
    logic [64:0]  div_trial;
    logic         div_ge;
    logic [63:0]  sq_trial;
    logic [63:0]  sq_val;
    logic         sq_ge;

    always_comb
    begin
        div_trial = {rem_reg, acc_reg[63]};
        div_ge    = div_trial >= {1'b0, aux_reg};
        sq_val    = {rem_reg[61:0], acc_reg[63:62]};
        sq_trial  = {aux_reg[61:0], 2'b01};
        sq_ge     = sq_val >= sq_trial;

        acc_next  = acc_reg;
        aux_next  = aux_reg;
        rem_next  = rem_reg;
        prod_next = prod_reg;
        case (op)
            rts_pkg::ALU_DIV_LOAD:
            begin
                acc_next = opa;
                aux_next = opb;
                rem_next = '0;
            end
            rts_pkg::ALU_DIV_STEP:
            begin
                rem_next = div_ge ? 64'(div_trial - {1'b0, aux_reg}) : div_trial[63:0];
                acc_next = {acc_reg[62:0], div_ge};
            end
            rts_pkg::ALU_MUL_LOAD:
            begin
                aux_next  = opa;
                acc_next  = opb;
                prod_next = '0;
            end
            rts_pkg::ALU_MUL_STEP:
            begin
                prod_next = {prod_reg[126:0], 1'b0}
                          + (acc_reg[63] ? {64'd0, aux_reg} : 128'd0);
                acc_next  = {acc_reg[62:0], 1'b0};
            end
            rts_pkg::ALU_SQRT_LOAD:
            begin
                acc_next = opa;
                aux_next = '0;
                rem_next = '0;
            end
            rts_pkg::ALU_SQRT_STEP:
            begin
                rem_next = sq_ge ? (sq_val - sq_trial) : sq_val;
                aux_next = {aux_reg[62:0], sq_ge};
                acc_next = {acc_reg[61:0], 2'b00};
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        aux_reg  <= aux_next;
        rem_reg  <= rem_next;
        prod_reg <= prod_next;
    end

    assign quotient     = acc_reg;
    assign root         = aux_reg[31:0];
    // saturate the product shifted down by 32
    assign product_term = (prod_reg[127:96] != 32'd0) ? '1 : prod_reg[95:32];

endmodule

`default_nettype wire

FILE: hw/rtl/rts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rts_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rts_pkg::ctrl_in_t  ctl_in,
    output rts_pkg::ctrl_out_t      ctl_out
);
    rts_pkg::state_t state_reg, state_next;
    logic [rts_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic stepping;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rts_pkg::ST_IDLE:
                if (ctl_in.fire)
                    state_next = ctl_in.add_item ? rts_pkg::ST_MEAN_PREP
                                                 : rts_pkg::ST_JIT_CHECK;
            rts_pkg::ST_MEAN_PREP: state_next = rts_pkg::ST_MEAN_DIV;
            rts_pkg::ST_MEAN_DIV:
                if (step_reg == rts_pkg::LAST_WIDE_STEP)
                    state_next = rts_pkg::ST_MEAN_UPD;
            rts_pkg::ST_MEAN_UPD:  state_next = rts_pkg::ST_DEV_PREP;
            rts_pkg::ST_DEV_PREP:  state_next = rts_pkg::ST_DEV_MUL;
            rts_pkg::ST_DEV_MUL:
                if (step_reg == rts_pkg::LAST_WIDE_STEP)
                    state_next = rts_pkg::ST_DEV_UPD;
            rts_pkg::ST_DEV_UPD:   state_next = rts_pkg::ST_JIT_CHECK;
            rts_pkg::ST_JIT_CHECK:
                state_next = ctl_in.jit_needed ? rts_pkg::ST_JIT_DIV : rts_pkg::ST_DONE;
            rts_pkg::ST_JIT_DIV:
                if (step_reg == rts_pkg::LAST_WIDE_STEP)
                    state_next = rts_pkg::ST_SQRT_PREP;
            rts_pkg::ST_SQRT_PREP: state_next = rts_pkg::ST_SQRT;
            rts_pkg::ST_SQRT:
                if (step_reg == rts_pkg::LAST_ROOT_STEP)
                    state_next = rts_pkg::ST_DONE;
            rts_pkg::ST_DONE:
                if (ctl_in.out_free)
                    state_next = rts_pkg::ST_IDLE;
            default:               state_next = rts_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl_out.state = state_reg;
        ctl_out.op    = rts_pkg::ALU_HOLD;
        stepping      = 1'b0;
        case (state_reg)
            rts_pkg::ST_MEAN_PREP: ctl_out.op = rts_pkg::ALU_DIV_LOAD;
            rts_pkg::ST_MEAN_DIV:
            begin
                ctl_out.op = rts_pkg::ALU_DIV_STEP;
                stepping   = 1'b1;
            end
            rts_pkg::ST_DEV_PREP:  ctl_out.op = rts_pkg::ALU_MUL_LOAD;
            rts_pkg::ST_DEV_MUL:
            begin
                ctl_out.op = rts_pkg::ALU_MUL_STEP;
                stepping   = 1'b1;
            end
            rts_pkg::ST_JIT_CHECK: ctl_out.op = rts_pkg::ALU_DIV_LOAD;
            rts_pkg::ST_JIT_DIV:
            begin
                ctl_out.op = rts_pkg::ALU_DIV_STEP;
                stepping   = 1'b1;
            end
            rts_pkg::ST_SQRT_PREP: ctl_out.op = rts_pkg::ALU_SQRT_LOAD;
            rts_pkg::ST_SQRT:
            begin
                ctl_out.op = rts_pkg::ALU_SQRT_STEP;
                stepping   = 1'b1;
            end
            default:               ctl_out.op = rts_pkg::ALU_HOLD;
        endcase
        // restart the count whenever a run of steps ends
        step_next = (stepping && state_next == state_reg) ? step_reg + 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rts_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/running_time_statistics_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Beat contents
// in_ch    in   command (add / clear), sample (signed Q15.16 ms)
// out_ch   out  status, count, average, smallest, largest, jitter
//
// An added sample holds the shared unit from its accepting edge to its result beat:
// the mean divide, the deviation product, then, with two or more samples held,
// the jitter divide and square root, and last the load of the result. A clear or
// a rejected sample skips the mean and product passes; the jitter divide and
// square root still run with two or more samples held. in_ch is not ready while
// an item is being worked on. The result is held in an output register, so the
// next item is taken while it waits; a finished item stalls only if the previous
// result has not yet been taken.
// Reset zeroes all statistics.
module running_time_statistics_core #(
    parameter int COUNT_BITS  = 32,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rts_in_if.sink     in_ch,
    rts_out_if.source  out_ch
);
    localparam int MEAN_BITS = SAMPLE_BITS + 16;

    rts_pkg::ctrl_in_t  ctl_in;
    rts_pkg::ctrl_out_t ctl_out;

    // statistics
    logic [COUNT_BITS-1:0]  total_reg;
    logic [MEAN_BITS-1:0]   mean_reg;
    logic [63:0]            dev_reg;
    logic [SAMPLE_BITS-2:0] min_reg;
    logic [SAMPLE_BITS-2:0] max_reg;
    logic [1:0]             status_reg;

    // working item
    logic [SAMPLE_BITS-2:0] raw_reg;
    logic [MEAN_BITS-1:0]   d1_reg;
    logic                   pos1_reg;
    logic                   pos2_reg;
    logic                   d2_zero_reg;

    // result register
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [31:0] out_count_reg;
    logic [30:0] out_average_reg;
    logic [30:0] out_smallest_reg;
    logic [30:0] out_largest_reg;
    logic [30:0] out_jitter_reg;

    logic [63:0] alu_a;
    logic [63:0] alu_b;
    logic [63:0] quotient;
    logic [63:0] product_term;
    logic [31:0] root;

    logic                 fire;
    logic                 neg_in;
    logic                 full;
    logic [MEAN_BITS-1:0] s_val;
    logic                 pos_now;
    logic [MEAN_BITS-1:0] d_now;
    logic [MEAN_BITS-1:0] q_val;
    logic [64:0]          dev_sum;
    logic                 dev_add;
    logic [COUNT_BITS-1:0] n_val;
    logic [30:0]          jit_val;

    assign fire   = in_ch.valid && in_ch.ready;
    assign neg_in = in_ch.sample[SAMPLE_BITS-1];
    assign full   = (total_reg == '1);
    assign in_ch.ready = (ctl_out.state == rts_pkg::ST_IDLE);

    assign ctl_in.fire       = fire;
    assign ctl_in.add_item   = (in_ch.command == rts_pkg::CMD_ADD) && !neg_in && !full;
    assign ctl_in.jit_needed = (total_reg > COUNT_BITS'(1));
    assign ctl_in.out_free   = !out_valid_reg || out_ch.ready;

    rts_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_in),
        .ctl_out (ctl_out)
    );

    // deviation of the held sample from the current mean
    always_comb
    begin
        s_val   = {1'b0, raw_reg, 16'd0};
        pos_now = s_val >= mean_reg;
        d_now   = pos_now ? (s_val - mean_reg) : (mean_reg - s_val);
        q_val   = quotient[MEAN_BITS-1:0];
        n_val   = total_reg + COUNT_BITS'(1);
        dev_add = (pos1_reg == pos2_reg) || (d1_reg == '0) || d2_zero_reg;
        dev_sum = dev_add ? ({1'b0, dev_reg} + {1'b0, product_term})
                          : ({1'b0, dev_reg} - {1'b0, product_term});
        jit_val = root[31] ? rts_pkg::JITTER_MAX : root[30:0];
    end

    // operand selection for the shared unit
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        case (ctl_out.state)
            rts_pkg::ST_MEAN_PREP:
            begin
                alu_a = 64'(d_now);
                alu_b = 64'(n_val);
            end
            rts_pkg::ST_DEV_PREP:
            begin
                alu_a = 64'(d1_reg);
                alu_b = 64'(d_now);
            end
            rts_pkg::ST_JIT_CHECK:
            begin
                alu_a = dev_reg;
                alu_b = 64'(total_reg - COUNT_BITS'(1));
            end
            rts_pkg::ST_SQRT_PREP:
            begin
                alu_a = quotient;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    rts_alu u_alu (
        .clk          (clk),
        .op           (ctl_out.op),
        .opa          (alu_a),
        .opb          (alu_b),
        .quotient     (quotient),
        .product_term (product_term),
        .root         (root)
    );

    // statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            mean_reg   <= '0;
            dev_reg    <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            status_reg <= rts_pkg::STATUS_OK;
        end
        else
        begin
            if (fire)
            begin
                if (in_ch.command == rts_pkg::CMD_CLEAR)
                begin
                    total_reg  <= '0;
                    mean_reg   <= '0;
                    dev_reg    <= '0;
                    min_reg    <= '0;
                    max_reg    <= '0;
                    status_reg <= rts_pkg::STATUS_OK;
                end
                else if (neg_in)
                begin
                    status_reg <= rts_pkg::STATUS_NEGATIVE;
                end
                else if (full)
                begin
                    status_reg <= rts_pkg::STATUS_FULL;
                end
            end
            if (ctl_out.state == rts_pkg::ST_MEAN_UPD)
            begin
                mean_reg <= pos1_reg ? (mean_reg + q_val) : (mean_reg - q_val);
            end
            if (ctl_out.state == rts_pkg::ST_DEV_UPD)
            begin
                // saturate upward, clamp at zero downward
                if (dev_sum[64])
                    dev_reg <= dev_add ? '1 : '0;
                else
                    dev_reg <= dev_sum[63:0];
                if (total_reg == '0)
                begin
                    min_reg <= raw_reg;
                    max_reg <= raw_reg;
                end
                else
                begin
                    if (raw_reg < min_reg)
                        min_reg <= raw_reg;
                    if (raw_reg > max_reg)
                        max_reg <= raw_reg;
                end
                total_reg  <= n_val;
                status_reg <= rts_pkg::STATUS_OK;
            end
        end
    end

    // working item payload
    always_ff @(posedge clk)
    begin
        if (fire)
            raw_reg <= in_ch.sample[SAMPLE_BITS-2:0];
        if (ctl_out.state == rts_pkg::ST_MEAN_PREP)
        begin
            d1_reg   <= d_now;
            pos1_reg <= pos_now;
        end
        if (ctl_out.state == rts_pkg::ST_DEV_PREP)
        begin
            pos2_reg    <= pos_now;
            d2_zero_reg <= (d_now == '0);
        end
    end

    // result register: load when the item is done and the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl_out.state == rts_pkg::ST_DONE && ctl_in.out_free)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl_out.state == rts_pkg::ST_DONE && ctl_in.out_free)
        begin
            out_status_reg   <= status_reg;
            out_count_reg    <= 32'(total_reg);
            out_average_reg  <= 31'(mean_reg[MEAN_BITS-1:16]);
            out_smallest_reg <= 31'(min_reg);
            out_largest_reg  <= 31'(max_reg);
            out_jitter_reg   <= ctl_in.jit_needed ? jit_val : 31'd0;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.status   = out_status_reg;
    assign out_ch.count    = out_count_reg;
    assign out_ch.average  = out_average_reg;
    assign out_ch.smallest = out_smallest_reg;
    assign out_ch.largest  = out_largest_reg;
    assign out_ch.jitter   = out_jitter_reg;

    // a clear leaves no samples behind
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_ch.command == rts_pkg::CMD_CLEAR |=> total_reg == '0)
        else $error("count not cleared");

    // bounds stay ordered once a sample is held
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg != '0 |-> min_reg <= max_reg)
        else $error("minimum above maximum");

    // a result is loaded only into a free slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> $stable(out_status_reg) && $stable(out_jitter_reg))
        else $error("waiting result overwritten");

    // the count moves only when an added sample completes or on a clear
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !fire && ctl_out.state != rts_pkg::ST_DEV_UPD |=> $stable(total_reg))
        else $error("count changed unexpectedly");

endmodule

`default_nettype wire
